FILE: hw/rtl/sate_pkg.sv
// Shared types and constants of the summed-area table engine.
// Depends on nothing; used by sate_cfg, sate_core and the top level.
package sate_pkg;

    // fixed field widths of the stream items
    localparam int VALUE_W   = 16;
    localparam int COORD_W   = 6;
    localparam int RECT_W    = 28;
    localparam int REG_W     = 7;
    localparam int IDX_W     = 2;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // register reset value and register indexes
    localparam logic [REG_W-1:0] REG_RESET = 7'd64;
    localparam logic [IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLS  = 2'd1;

    // request kinds
    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [1:0]
    {
        STATUS_OK         = 2'd0,
        STATUS_BAD_RECT   = 2'd1,
        STATUS_INCOMPLETE = 2'd2
    } status_t;

    // one input request
    typedef struct packed
    {
        cmd_t               cmd;
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] west_col;
        logic [COORD_W-1:0] east_col;
        logic [COORD_W-1:0] south_row;
        logic [COORD_W-1:0] north_row;
    } item_t;

    // one result
    typedef struct packed
    {
        logic [RECT_W-1:0] rect_sum;
        status_t           status;
        logic              table_full;
    } result_t;

    // effective grid size and restart pulse from the register block
    typedef struct packed
    {
        logic [REG_W-1:0] rows;
        logic [REG_W-1:0] cols;
        logic             restart;
    } cfg_t;

endpackage

FILE: hw/rtl/sate_cfg.sv
// Register block of the summed-area table engine: grid size registers,
// clamping to the memory size and the restart pulse. Uses sate_pkg.
module sate_cfg #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sate_pkg::IDX_W-1:0]    cfg_index,
    input  logic [sate_pkg::REG_W-1:0]    cfg_data,
    output sate_pkg::cfg_t                cfg
);

    localparam int RCMP_W = ($clog2(MAX_ROWS + 1) > sate_pkg::REG_W) ?
                            $clog2(MAX_ROWS + 1) : sate_pkg::REG_W;
    localparam int CCMP_W = ($clog2(MAX_COLS + 1) > sate_pkg::REG_W) ?
                            $clog2(MAX_COLS + 1) : sate_pkg::REG_W;

    logic [sate_pkg::REG_W-1:0] rows_reg;
    logic [sate_pkg::REG_W-1:0] cols_reg;
    logic                       wr_rows;
    logic                       wr_cols;

    assign cfg_ready = 1'b1;
    assign wr_rows   = cfg_valid && (cfg_index == sate_pkg::REG_ROWS);
    assign wr_cols   = cfg_valid && (cfg_index == sate_pkg::REG_COLS);

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= sate_pkg::REG_RESET;
            cols_reg <= sate_pkg::REG_RESET;
        end
        else
        begin
            if (wr_rows)
            begin
                rows_reg <= cfg_data;
            end
            if (wr_cols)
            begin
                cols_reg <= cfg_data;
            end
        end
    end

    // zero acts as one, anything above the memory size as the maximum
    always_comb
    begin
        if (rows_reg == '0)
            cfg.rows = sate_pkg::REG_W'(1);
        else if (RCMP_W'(rows_reg) > RCMP_W'(MAX_ROWS))
            cfg.rows = sate_pkg::REG_W'(MAX_ROWS);
        else
            cfg.rows = rows_reg;

        if (cols_reg == '0)
            cfg.cols = sate_pkg::REG_W'(1);
        else if (CCMP_W'(cols_reg) > CCMP_W'(MAX_COLS))
            cfg.cols = sate_pkg::REG_W'(MAX_COLS);
        else
            cfg.cols = cols_reg;

        cfg.restart = wr_rows || wr_cols;
    end

endmodule

FILE: hw/rtl/sate_mem.sv
// Table memory: one write port and two read ports with registered read data.
// Depends on nothing.
module sate_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 28
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two read ports with registered read data
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: hw/rtl/sate_core.sv
// Sequencer of the summed-area table engine: load read-modify-write,
// four-corner query with two corners read at a time, result register. Uses sate_pkg.
module sate_core #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 16,
    parameter int SUM_BITS   = 28,
    parameter int ADDR_W     = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sate_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sate_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sate_pkg::result_t    out_result,
    output logic                 mem_wr_en,
    output logic [ADDR_W-1:0]    mem_wr_addr,
    output logic [SUM_BITS-1:0]  mem_wr_data,
    output logic [ADDR_W-1:0]    mem_rd_addr_a,
    output logic [ADDR_W-1:0]    mem_rd_addr_b,
    input  logic [SUM_BITS-1:0]  mem_rd_data_a,
    input  logic [SUM_BITS-1:0]  mem_rd_data_b
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MAX_RC = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int DIM_W  = ((MAX_RC > sate_pkg::REG_W) ? MAX_RC : sate_pkg::REG_W) + 1;
    localparam int EXT_W  = (SUM_BITS > sate_pkg::RECT_W) ? SUM_BITS : sate_pkg::RECT_W;
    localparam logic [sate_pkg::VALUE_W-1:0] VAL_MASK =
        (VALUE_BITS >= sate_pkg::VALUE_W) ? {sate_pkg::VALUE_W{1'b1}} :
        sate_pkg::VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_QUERY2,
        ST_EXEC
    } state_t;

    // entry address of a row and a column
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    // query coordinate to memory row index
    function automatic logic [ROW_W-1:0] row_idx(input logic [sate_pkg::COORD_W-1:0] x);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(x);
        return ext[ROW_W-1:0];
    endfunction

    // query coordinate to memory column index
    function automatic logic [COL_W-1:0] col_idx(input logic [sate_pkg::COORD_W-1:0] x);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(x);
        return ext[COL_W-1:0];
    endfunction

    state_t                 state_reg;
    sate_pkg::item_t        item_reg;
    logic [ROW_W-1:0]       load_row_reg;
    logic [COL_W-1:0]       load_col_reg;
    logic [SUM_BITS-1:0]    run_sum_reg;
    logic                   loaded_reg;
    logic [ROW_W-1:0]       ld_row_reg;
    logic [COL_W-1:0]       ld_col_reg;
    logic [ADDR_W-1:0]      ld_addr_reg;
    logic [ADDR_W-1:0]      below_addr_reg;
    logic                   below_zero_reg;
    logic [SUM_BITS-1:0]    run_new_reg;
    logic [SUM_BITS-1:0]    ab_reg;
    logic                   out_valid_reg;
    sate_pkg::result_t      out_reg;

    logic                   accept;
    logic                   slot_free;
    logic                   pos_restart;
    logic [DIM_W-1:0]       rows_ext;
    logic [DIM_W-1:0]       cols_ext;
    logic [ROW_W-1:0]       eff_row;
    logic [COL_W-1:0]       eff_col;
    logic [SUM_BITS-1:0]    eff_run;
    logic [SUM_BITS-1:0]    run_new;
    logic [ADDR_W-1:0]      below_addr;
    logic [ADDR_W-1:0]      ld_addr;
    logic [sate_pkg::COORD_W-1:0] in_south_m1;
    logic [sate_pkg::COORD_W-1:0] reg_south_m1;
    logic [sate_pkg::COORD_W-1:0] reg_west_m1;
    logic [ADDR_W-1:0]      a_addr;
    logic [ADDR_W-1:0]      b_addr;
    logic [ADDR_W-1:0]      c_addr;
    logic [ADDR_W-1:0]      d_addr;
    logic                   s_zero;
    logic                   w_zero;
    logic [SUM_BITS-1:0]    ab_next;
    logic [SUM_BITS-1:0]    q_sum;
    logic [EXT_W-1:0]       q_sum_ext;
    logic                   bad_rect;
    logic [COL_W:0]         col_inc;
    logic [ROW_W:0]         row_inc;
    logic                   row_done;
    logic                   grid_done;
    sate_pkg::result_t      result_next;
    logic                   loaded_next;

    assign rows_ext  = DIM_W'(cfg.rows);
    assign cols_ext  = DIM_W'(cfg.cols);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;

    // position of the next load, restarted after a full grid
    assign pos_restart = loaded_reg || (DIM_W'(load_row_reg) >= rows_ext) ||
                         (DIM_W'(load_col_reg) >= cols_ext);
    assign eff_row    = pos_restart ? '0 : load_row_reg;
    assign eff_col    = pos_restart ? '0 : load_col_reg;
    assign eff_run    = pos_restart ? '0 : run_sum_reg;
    assign run_new    = eff_run + SUM_BITS'(in_item.value & VAL_MASK);
    assign below_addr = entry_addr(eff_row - ROW_W'(1), eff_col);
    assign ld_addr    = entry_addr(eff_row, eff_col);

    // four corners: two at accept, two on the following cycle
    assign in_south_m1  = in_item.south_row - sate_pkg::COORD_W'(1);
    assign reg_south_m1 = item_reg.south_row - sate_pkg::COORD_W'(1);
    assign reg_west_m1  = item_reg.west_col - sate_pkg::COORD_W'(1);
    assign a_addr = entry_addr(row_idx(in_item.north_row), col_idx(in_item.east_col));
    assign b_addr = entry_addr(row_idx(in_south_m1), col_idx(in_item.east_col));
    assign c_addr = entry_addr(row_idx(item_reg.north_row), col_idx(reg_west_m1));
    assign d_addr = entry_addr(row_idx(reg_south_m1), col_idx(reg_west_m1));
    assign s_zero = (item_reg.south_row == '0);
    assign w_zero = (item_reg.west_col == '0);

    // memory read address selection
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mem_rd_addr_a = (in_item.cmd == sate_pkg::CMD_QUERY) ? a_addr : below_addr;
            mem_rd_addr_b = b_addr;
        end
        else
        begin
            mem_rd_addr_a = (item_reg.cmd == sate_pkg::CMD_QUERY) ? c_addr : below_addr_reg;
            mem_rd_addr_b = d_addr;
        end
    end

    // load write-back
    assign mem_wr_en   = (state_reg == ST_EXEC) && slot_free &&
                         (item_reg.cmd == sate_pkg::CMD_LOAD);
    assign mem_wr_addr = ld_addr_reg;
    assign mem_wr_data = run_new_reg + (below_zero_reg ? '0 : mem_rd_data_a);

    // query arithmetic
    assign ab_next   = mem_rd_data_a - (s_zero ? '0 : mem_rd_data_b);
    assign q_sum     = ab_reg - (w_zero ? '0 : mem_rd_data_a) +
                       ((s_zero || w_zero) ? '0 : mem_rd_data_b);
    assign q_sum_ext = EXT_W'(q_sum);
    assign bad_rect  = (item_reg.west_col > item_reg.east_col) ||
                       (item_reg.south_row > item_reg.north_row) ||
                       (DIM_W'(item_reg.east_col) >= cols_ext) ||
                       (DIM_W'(item_reg.north_row) >= rows_ext);

    // load position advance
    assign col_inc   = {1'b0, ld_col_reg} + (COL_W + 1)'(1);
    assign row_inc   = {1'b0, ld_row_reg} + (ROW_W + 1)'(1);
    assign row_done  = (DIM_W'(col_inc) >= cols_ext);
    assign grid_done = row_done && (DIM_W'(row_inc) >= rows_ext);

    // result of the request in execution
    always_comb
    begin
        result_next = '0;
        loaded_next = loaded_reg;
        if (item_reg.cmd == sate_pkg::CMD_LOAD)
        begin
            loaded_next = grid_done;
            result_next.status = sate_pkg::STATUS_OK;
        end
        else if (!loaded_reg)
        begin
            result_next.status = sate_pkg::STATUS_INCOMPLETE;
        end
        else if (bad_rect)
        begin
            result_next.status = sate_pkg::STATUS_BAD_RECT;
        end
        else
        begin
            result_next.status   = sate_pkg::STATUS_OK;
            result_next.rect_sum = q_sum_ext[sate_pkg::RECT_W-1:0];
        end
        result_next.table_full = loaded_next;
    end

    // sequencer, load state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            run_sum_reg    <= '0;
            loaded_reg     <= 1'b0;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            ld_addr_reg    <= '0;
            below_addr_reg <= '0;
            below_zero_reg <= 1'b0;
            run_new_reg    <= '0;
            ab_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            // result valid: set when a request completes, cleared once taken
            if ((state_reg == ST_EXEC) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg       <= in_item;
                        ld_row_reg     <= eff_row;
                        ld_col_reg     <= eff_col;
                        ld_addr_reg    <= ld_addr;
                        below_addr_reg <= below_addr;
                        below_zero_reg <= (eff_row == '0);
                        run_new_reg    <= run_new;
                        state_reg <= (in_item.cmd == sate_pkg::CMD_QUERY) ?
                                     ST_QUERY2 : ST_EXEC;
                    end
                end
                ST_QUERY2:
                begin
                    ab_reg    <= ab_next;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (slot_free)
                    begin
                        out_reg   <= result_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // load position: a write to the row or column register restarts loading
            if (cfg.restart)
            begin
                load_row_reg <= '0;
                load_col_reg <= '0;
                run_sum_reg  <= '0;
                loaded_reg   <= 1'b0;
            end
            else if (mem_wr_en)
            begin
                loaded_reg <= loaded_next;
                if (row_done)
                begin
                    load_col_reg <= '0;
                    run_sum_reg  <= '0;
                    load_row_reg <= grid_done ? '0 : row_inc[ROW_W-1:0];
                end
                else
                begin
                    load_col_reg <= col_inc[COL_W-1:0];
                    load_row_reg <= ld_row_reg;
                    run_sum_reg  <= run_new_reg;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/summed_area_table_engine_top.sv
// Summed-area table engine: a load request reads the entry below, then writes
// back the new entry; a query takes two rectangle corners through the two read
// ports of the table memory, then the other two, then forms the sum. One request
// is in work at a time; a finished result waits in the output register while
// the next request is taken. The table memory needs no clearing after reset: a
// query is answered only once a whole grid has been loaded.
// Holds sate_cfg, sate_core and sate_mem; uses sate_pkg.
module summed_area_table_engine_top #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 16,
    parameter int SUM_BITS   = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // value[15:0], west_col[21:16], east_col[27:22], south_row[33:28], north_row[39:34]
    input  logic [sate_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[0]
    input  logic [sate_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rect_sum[27:0], zero[31:28]
    output logic [sate_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0], table_full[2]
    output logic [sate_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sate_pkg::IDX_W-1:0]        cfg_index,
    input  logic [sate_pkg::REG_W-1:0]        cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sate_pkg::cfg_t      cfg;
    sate_pkg::item_t     item;
    sate_pkg::result_t   result;
    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [SUM_BITS-1:0] mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr_a;
    logic [ADDR_W-1:0]   mem_rd_addr_b;
    logic [SUM_BITS-1:0] mem_rd_data_a;
    logic [SUM_BITS-1:0] mem_rd_data_b;

    // unpack the request
    assign item.cmd       = sate_pkg::cmd_t'(s_tuser[0]);
    assign item.value     = s_tdata[15:0];
    assign item.west_col  = s_tdata[21:16];
    assign item.east_col  = s_tdata[27:22];
    assign item.south_row = s_tdata[33:28];
    assign item.north_row = s_tdata[39:34];

    // pack the result
    assign m_tdata = sate_pkg::M_TDATA_W'(result.rect_sum);
    assign m_tuser = {result.table_full, result.status};

    // grid size registers
    sate_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    sate_core #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS),
        .ADDR_W     (ADDR_W)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (result),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b)
    );

    // table memory
    sate_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_BITS)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking bench for summed_area_table_engine_top: streams load and query
// requests, predicts every result and compares each one as it leaves the block.
// Depends on sate_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

    import sate_pkg::*;

    localparam int GRID_ROWS        = 64;
    localparam int GRID_COLS        = 64;
    localparam int RANDOM_ITEMS     = 600;
    localparam int CALM_ITEMS       = 60;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 96;
    localparam int TAIL_CYCLES      = 16;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int REPORT_LIMIT     = 10;

    // register index that the block decodes to nothing
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0]
    {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN,
        OP_HOLD
    } op_kind_t;

    typedef struct
    {
        op_kind_t          kind;
        item_t             req;
        logic [IDX_W-1:0]  idx;
        logic [REG_W-1:0]  data;
        bit                calm;
    } stim_op_t;

    // dut ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [REG_W-1:0]      cfg_data = '0;

    // stimulus and scoreboard
    stim_op_t              op_q[$];
    result_t               expected_results[$];
    int                    results_expected = 0;
    int                    results_seen = 0;
    int                    err_count = 0;
    logic                  hold_req = 1'b0;
    logic                  tail_quiet = 1'b0;

    // predictor state
    logic [RECT_W-1:0]     sat_mem [GRID_ROWS*GRID_COLS];
    logic [RECT_W-1:0]     run_sum;
    int                    ld_row;
    int                    ld_col;
    bit                    table_done;
    logic [REG_W-1:0]      rows_reg;
    logic [REG_W-1:0]      cols_reg;

    // generator bookkeeping
    int                    plan_rows;
    int                    plan_cols;
    bit                    in_random;
    int                    n_rand;

    summed_area_table_engine_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and single reset
    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // register value as the block uses it
    function automatic int grid_dim(logic [REG_W-1:0] raw, int lim);
        if (raw == '0)
            return 1;
        return (int'(raw) > lim) ? lim : int'(raw);
    endfunction

    function automatic void restart_table();
        run_sum    = '0;
        ld_row     = 0;
        ld_col     = 0;
        table_done = 1'b0;
    endfunction

    // table entry with the zero border: indexes are one above row and column
    function automatic logic [RECT_W-1:0] sat_at(int row_up, int col_up);
        if (row_up == 0 || col_up == 0)
            return '0;
        return sat_mem[(row_up - 1) * GRID_COLS + (col_up - 1)];
    endfunction

    function automatic void sat_write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        if (idx == REG_ROWS)
        begin
            rows_reg = data;
            restart_table();
        end
        else if (idx == REG_COLS)
        begin
            cols_reg = data;
            restart_table();
        end
    endfunction

    function automatic result_t sat_predict(item_t req);
        result_t           res;
        int                rows;
        int                cols;
        int                w;
        int                e;
        int                s;
        int                n;
        logic [RECT_W-1:0] below;
        res.rect_sum   = '0;
        res.status     = STATUS_OK;
        rows = grid_dim(rows_reg, GRID_ROWS);
        cols = grid_dim(cols_reg, GRID_COLS);
        if (req.cmd == CMD_LOAD)
        begin
            // a load after a full grid opens a new table
            if (table_done)
                restart_table();
            if (ld_row >= rows || ld_col >= cols)
            begin
                ld_row  = 0;
                ld_col  = 0;
                run_sum = '0;
            end
            run_sum = run_sum + RECT_W'(req.value);
            below   = sat_at(ld_row, ld_col + 1);
            sat_mem[ld_row * GRID_COLS + ld_col] = run_sum + below;
            ld_col++;
            if (ld_col >= cols)
            begin
                ld_col  = 0;
                run_sum = '0;
                ld_row++;
                if (ld_row >= rows)
                begin
                    ld_row     = 0;
                    table_done = 1'b1;
                end
            end
        end
        else
        begin
            w = int'(req.west_col);
            e = int'(req.east_col);
            s = int'(req.south_row);
            n = int'(req.north_row);
            if (!table_done)
                res.status = STATUS_INCOMPLETE;
            else if (w > e || s > n || e >= cols || n >= rows)
                res.status = STATUS_BAD_RECT;
            else
                res.rect_sum = sat_at(n + 1, e + 1) - sat_at(s, e + 1)
                             - sat_at(n + 1, w) + sat_at(s, w);
        end
        res.table_full = table_done;
        return res;
    endfunction

    initial
    begin
        foreach (sat_mem[k])
            sat_mem[k] = '0;
        rows_reg = REG_RESET;
        cols_reg = REG_RESET;
        restart_table();
    end

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------

    function automatic void add_item(item_t req);
        stim_op_t op;
        op.kind = OP_ITEM;
        op.req  = req;
        op.idx  = '0;
        op.data = '0;
        op.calm = in_random && (n_rand >= RANDOM_ITEMS - CALM_ITEMS);
        op_q.push_back(op);
        if (in_random)
            n_rand++;
    endfunction

    function automatic item_t noise_item();
        item_t req;
        req.cmd       = cmd_t'($urandom_range(0, 1));
        req.value     = VALUE_W'($urandom());
        req.west_col  = COORD_W'($urandom());
        req.east_col  = COORD_W'($urandom());
        req.south_row = COORD_W'($urandom());
        req.north_row = COORD_W'($urandom());
        return req;
    endfunction

    function automatic void queue_load(logic [VALUE_W-1:0] value);
        item_t req;
        req       = noise_item();
        req.cmd   = CMD_LOAD;
        req.value = value;
        add_item(req);
    endfunction

    function automatic void queue_query(int w, int e, int s, int n);
        item_t req;
        req           = noise_item();
        req.cmd       = CMD_QUERY;
        req.west_col  = COORD_W'(w);
        req.east_col  = COORD_W'(e);
        req.south_row = COORD_W'(s);
        req.north_row = COORD_W'(n);
        add_item(req);
    endfunction

    function automatic void queue_sync(op_kind_t kind, logic [IDX_W-1:0] idx,
                                       logic [REG_W-1:0] data);
        stim_op_t op;
        op.kind = kind;
        op.req  = '0;
        op.idx  = idx;
        op.data = data;
        op.calm = 1'b0;
        op_q.push_back(op);
        if (kind == OP_CFG && idx == REG_ROWS)
            plan_rows = grid_dim(data, GRID_ROWS);
        if (kind == OP_CFG && idx == REG_COLS)
            plan_cols = grid_dim(data, GRID_COLS);
    endfunction

    function automatic void queue_good_query();
        int w;
        int e;
        int s;
        int n;
        w = $urandom_range(0, plan_cols - 1);
        e = $urandom_range(w, plan_cols - 1);
        s = $urandom_range(0, plan_rows - 1);
        n = $urandom_range(s, plan_rows - 1);
        queue_query(w, e, s, n);
    endfunction

    function automatic logic [VALUE_W-1:0] grid_value();
        case ($urandom_range(0, 7))
            0, 1:    return '1;
            2:       return '0;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [REG_W-1:0] extreme_reg();
        case ($urandom_range(0, 3))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            default: return 7'd127;
        endcase
    endfunction

    initial
    begin : stimulus
        int               shape;
        int               cells;
        int               i;
        bit               hold_done;
        bit               drain_done;
        logic [REG_W-1:0] new_rows;
        logic [REG_W-1:0] new_cols;

        plan_rows  = GRID_ROWS;
        plan_cols  = GRID_COLS;
        in_random  = 1'b0;
        n_rand     = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        // directed: query before load, partial table at reset size
        queue_query(0, 63, 0, 63);
        queue_load('1);
        queue_query(0, 0, 0, 0);

        // register zero acts as one row; two columns
        queue_sync(OP_CFG, REG_ROWS, 7'd0);
        queue_sync(OP_CFG, REG_COLS, 7'd2);
        queue_load('1);
        queue_load(16'h0001);
        queue_query(0, 1, 0, 0);
        queue_query(1, 1, 0, 0);
        queue_query(0, 0, 0, 0);
        // reversed, outside and all-ones rectangles
        queue_query(1, 0, 0, 0);
        queue_query(0, 0, 1, 0);
        queue_query(0, 2, 0, 0);
        queue_query(0, 0, 0, 1);
        queue_query(63, 63, 63, 63);

        // write to an unused index keeps the table
        queue_sync(OP_CFG, REG_SPARE, 7'h7F);
        queue_query(0, 1, 0, 0);

        // load after a full table opens a new one
        queue_load('0);
        queue_query(0, 1, 0, 0);
        queue_load(16'h5A5A);
        queue_query(0, 1, 0, 0);

        // random phases, each with a fresh grid size
        in_random = 1'b1;
        while (n_rand < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    new_rows = extreme_reg();
                    new_cols = REG_W'($urandom_range(0, 2));
                end
                1:
                begin
                    new_rows = REG_W'($urandom_range(0, 2));
                    new_cols = extreme_reg();
                end
                default:
                begin
                    new_rows = REG_W'($urandom_range(1, 8));
                    new_cols = REG_W'($urandom_range(1, 8));
                end
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                queue_sync(OP_CFG, REG_ROWS, new_rows);
                if ($urandom_range(0, 3) != 0)
                    queue_sync(OP_CFG, REG_COLS, new_cols);
            end
            else
            begin
                queue_sync(OP_CFG, REG_COLS, new_cols);
                if ($urandom_range(0, 3) != 0)
                    queue_sync(OP_CFG, REG_ROWS, new_rows);
            end

            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                // broken sequence: arbitrary requests
                repeat ($urandom_range(4, 16))
                    add_item(noise_item());
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    add_item(noise_item());
                cells = plan_rows * plan_cols;
                for (i = 0; i < cells; i++)
                begin
                    queue_load(grid_value());
                    if ($urandom_range(0, 9) == 0)
                        queue_good_query();
                    // receiver stall while the sender keeps offering
                    if (!hold_done && n_rand > 150 && i > cells / 2 && cells - i > 8)
                    begin
                        queue_sync(OP_HOLD, '0, '0);
                        hold_done = 1'b1;
                    end
                    // sender waits for every result mid-table
                    if (i == cells / 2 && (!drain_done || $urandom_range(0, 7) == 0))
                    begin
                        queue_sync(OP_DRAIN, '0, '0);
                        drain_done = 1'b1;
                    end
                end
                repeat ($urandom_range(4, 12))
                begin
                    if ($urandom_range(0, 4) == 0)
                        add_item(noise_item());
                    else
                        queue_good_query();
                end
                // start another table and query it partly or fully loaded
                if (shape == 1)
                begin
                    repeat ($urandom_range(1, cells))
                        queue_load(grid_value());
                    queue_good_query();
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------
    int  gap_left = 0;
    int  quiet_cnt = 0;
    int  drv_cycle = 0;
    bit  drv_idle_on = 1'b0;
    item_t            cur_req;
    logic [IDX_W-1:0] cur_idx;
    logic [REG_W-1:0] cur_data;

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        stim_op_t op;
        logic     item_out;
        logic     reg_out;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left  = 0;
            quiet_cnt = 0;
        end
        else
        begin
            item_out = s_tvalid;
            reg_out  = cfg_valid;

            // accepted request: predict its result
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(sat_predict(cur_req));
                results_expected++;
                item_out = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                sat_write_reg(cur_idx, cur_data);
                reg_out = 1'b0;
            end

            if (results_seen == results_expected && !s_tvalid)
                quiet_cnt++;
            else
                quiet_cnt = 0;

            // idling comes and goes in stretches
            if (drv_cycle % 64 == 0)
                drv_idle_on = ($urandom_range(0, 2) != 0);
            drv_cycle++;

            // next request
            if (!item_out && !reg_out && op_q.size() != 0)
            begin
                op = op_q[0];
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    case (op.kind)
                        OP_ITEM:
                        begin
                            if (!op.calm && drv_idle_on && $urandom_range(0, 5) == 0)
                                gap_left = $urandom_range(1, 8);
                            else
                            begin
                                void'(op_q.pop_front());
                                cur_req = op.req;
                                s_tdata <= {op.req.north_row, op.req.south_row,
                                            op.req.east_col, op.req.west_col, op.req.value};
                                s_tuser <= op.req.cmd;
                                item_out = 1'b1;
                                if (op.calm)
                                    tail_quiet <= 1'b1;
                            end
                        end
                        OP_CFG:
                        begin
                            if (quiet_cnt >= SETTLE_CYCLES)
                            begin
                                void'(op_q.pop_front());
                                cur_idx   = op.idx;
                                cur_data  = op.data;
                                cfg_index <= op.idx;
                                cfg_data  <= op.data;
                                reg_out   = 1'b1;
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (results_seen == results_expected)
                                void'(op_q.pop_front());
                        end
                        default:
                        begin
                            void'(op_q.pop_front());
                            hold_req <= ~hold_req;
                        end
                    endcase
                end
            end

            s_tvalid  <= item_out;
            cfg_valid <= reg_out;
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stalls plus one long hold
    // ---------------------------------------------------------------
    int   stall_left = 0;
    int   rcv_cycle = 0;
    bit   rcv_idle_on = 1'b0;
    logic hold_seen = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rcv_cycle % 64 == 0)
                rcv_idle_on = ($urandom_range(0, 2) != 0);
            rcv_cycle++;
            if (hold_req != hold_seen)
            begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!tail_quiet && rcv_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready   <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result monitor and comparison
    // ---------------------------------------------------------------
    function automatic void flag_mismatch(string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("unexpected result tdata %h tuser %h",
                                        m_tdata, m_tuser));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[RECT_W-1:0] !== want.rect_sum
                    || m_tdata[M_TDATA_W-1:RECT_W] !== '0
                    || m_tuser[1:0] !== want.status
                    || m_tuser[2] !== want.table_full)
                    flag_mismatch($sformatf(
                        "rect_sum exp %0d got %0d pad %h, status exp %0d got %0d, full exp %0b got %0b",
                        want.rect_sum, m_tdata[RECT_W-1:0], m_tdata[M_TDATA_W-1:RECT_W],
                        want.status, m_tuser[1:0], want.table_full, m_tuser[2]));
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog on handshake activity
    // ---------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a request moving", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // end of run
    // ---------------------------------------------------------------
    initial
    begin : end_of_run
        @(posedge rst_n);
        while (op_q.size() != 0 || s_tvalid || cfg_valid)
            @(posedge clk);
        while (results_seen != results_expected)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sate_pkg.sv
hw/rtl/sate_cfg.sv
hw/rtl/sate_mem.sv
hw/rtl/sate_core.sv
hw/rtl/summed_area_table_engine_top.sv
dv/testbench.sv
